@@ rtl/core/oss_pkg.sv @@
// Shared definitions for the order statistic set: sizes, command and status
// codes, and the request bundle sent to the key store.
// No dependencies.
package oss_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;

    // Store address and fill count widths.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed widths of the stream fields.
    localparam int POS_W    = 7;
    localparam int CNTF_W   = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((KEY_WIDTH + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((KEY_WIDTH + 2 * CNTF_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_SELECT = 2'd2,
        CMD_RANK   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_RANGE  = 2'd1,
        STS_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_addr;
        logic [KEY_WIDTH-1:0] wr_data;
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_addr;
    } t_ram_req;

endpackage

@@ rtl/core/oss_key_ram.sv @@
// Key store of the order statistic set: one write and one registered read
// port per cycle. Depends on oss_pkg for its sizes and request bundle.
module oss_key_ram (
    input  logic                          i_clk,
    input  oss_pkg::t_ram_req             i_req,
    output logic [oss_pkg::KEY_WIDTH-1:0] o_rd_data
);

    logic [oss_pkg::KEY_WIDTH-1:0] r_mem [oss_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end

endmodule

@@ rtl/core/order_statistic_set.sv @@
// Top level of the order statistic set: command sequencer, binary search and
// shift engine around the key store. Depends on oss_pkg and oss_key_ram.
// Usage. Commands arrive on the slave stream, one per transfer: tuser holds the command
// (insert, erase, select by index, rank of key) and tdata the key and the select position.
// Every command produces exactly one result transfer on the master stream with the selected
// key, the rank, the set size after the command and, in tuser, the status.
// Timing. Insert, erase and rank run a binary search of s <= ceil(log2(n+1)) halving steps
// over the n stored keys, each a store read and then a compare, followed by a check that
// sees the window close and a decide step. Insert moves each larger key up and erase moves
// each larger key down, each key read from the store and then written back, followed by a
// step that places the key or drops the count. A done step closes the command and a hold
// step loads the result register. A select reads the store straight from the command
// transfer; a select out of range goes straight to the done step. Ready returns in the
// same cycle as the result becomes valid.
// Reset and stalls. Reset empties the set; the store needs no clearing since only entries
// below the fill count are read. A result waits in the output register while the receiver
// stalls; a new command is taken meanwhile but cannot complete until that result is taken.
module order_statistic_set (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, lowest bit up: key, position, zero fill.
    input  logic [oss_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: cmd.
    input  logic [oss_pkg::CMD_W-1:0]     s_axis_tuser,
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, lowest bit up: found_key, rank, set_size, zero fill.
    output logic [oss_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: status.
    output logic [oss_pkg::STATUS_W-1:0]  m_axis_tuser
);

    localparam int KW = oss_pkg::KEY_WIDTH;
    localparam int CW = oss_pkg::CNT_W;
    localparam int IW = oss_pkg::IDX_W;
    localparam int PW = oss_pkg::POS_W;
    localparam int CMPW = (CW > PW) ? CW : PW;
    localparam int CNTF_W_L = oss_pkg::CNTF_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SRCH     = 9'b000000010,
        ST_SRCH_CMP = 9'b000000100,
        ST_DECIDE   = 9'b000001000,
        ST_SHIFT    = 9'b000010000,
        ST_SHIFT_WR = 9'b000100000,
        ST_SEL_WAIT = 9'b001000000,
        ST_DONE     = 9'b010000000,
        ST_HOLD     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    oss_pkg::t_cmd    r_cmd, n_cmd;
    logic signed [KW-1:0] r_key, n_key;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_hit, n_hit;

    logic [KW-1:0]    r_found, n_found;
    logic [CW-1:0]    r_rank, n_rank;
    oss_pkg::t_status r_status, n_status;

    logic                  r_m_valid, n_m_valid;
    logic [KW-1:0]         r_m_found, n_m_found;
    logic [CNTF_W_L-1:0]   r_m_rank, n_m_rank;
    logic [CNTF_W_L-1:0]   r_m_size, n_m_size;
    oss_pkg::t_status      r_m_status, n_m_status;

    oss_pkg::t_ram_req     w_req;
    logic signed [KW-1:0]  w_rd_data;
    logic [CW:0]           w_sum;
    logic                  w_accept;

    oss_key_ram u_key_ram (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_sum         = {1'b0, r_lo} + {1'b0, r_hi};

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_count    = r_count;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_found    = r_found;
        n_rank     = r_rank;
        n_status   = r_status;
        n_m_valid  = r_m_valid;
        n_m_found  = r_m_found;
        n_m_rank   = r_m_rank;
        n_m_size   = r_m_size;
        n_m_status = r_m_status;
        w_req      = '0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd    = oss_pkg::t_cmd'(s_axis_tuser);
                    n_key    = s_axis_tdata[KW-1:0];
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_hit    = 1'b0;
                    n_found  = '0;
                    n_rank   = '0;
                    n_status = oss_pkg::STS_OK;
                    if (oss_pkg::t_cmd'(s_axis_tuser) == oss_pkg::CMD_SELECT) begin
                        if (CMPW'(s_axis_tdata[KW+PW-1:KW]) < CMPW'(r_count)) begin
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = IW'(s_axis_tdata[KW+PW-1:KW]);
                            n_state       = ST_SEL_WAIT;
                        end else begin
                            n_status = oss_pkg::STS_RANGE;
                            n_state  = ST_DONE;
                        end
                    end else begin
                        n_state = ST_SRCH;
                    end
                end
            end
            ST_SRCH: begin
                // One halving step of the lower-bound search.
                if (r_lo < r_hi) begin
                    n_mid         = w_sum[CW:1];
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = IW'(w_sum[CW:1]);
                    n_state       = ST_SRCH_CMP;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_SRCH_CMP: begin
                if (w_rd_data < r_key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                if (w_rd_data == r_key) begin
                    n_hit = 1'b1;
                end
                n_state = ST_SRCH;
            end
            ST_DECIDE: begin
                case (r_cmd)
                    oss_pkg::CMD_RANK: begin
                        n_rank  = r_lo;
                        n_state = ST_DONE;
                    end
                    oss_pkg::CMD_INSERT: begin
                        if (r_hit) begin
                            n_state = ST_DONE;
                        end else if (r_count >= CW'(oss_pkg::CAPACITY)) begin
                            n_status = oss_pkg::STS_FULL;
                            n_state  = ST_DONE;
                        end else begin
                            n_idx   = r_count;
                            n_state = ST_SHIFT;
                        end
                    end
                    oss_pkg::CMD_ERASE: begin
                        if (r_hit) begin
                            n_idx   = r_lo;
                            n_state = ST_SHIFT;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_SHIFT: begin
                if (r_cmd == oss_pkg::CMD_INSERT) begin
                    // Move keys above the insertion point up by one place.
                    if (r_idx > r_lo) begin
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = IW'(r_idx - CW'(1));
                        n_state       = ST_SHIFT_WR;
                    end else begin
                        w_req.wr_en   = 1'b1;
                        w_req.wr_addr = IW'(r_lo);
                        w_req.wr_data = r_key;
                        n_count       = r_count + CW'(1);
                        n_state       = ST_DONE;
                    end
                end else begin
                    // Close the gap left by the erased key.
                    if (({1'b0, r_idx} + (CW+1)'(1)) < {1'b0, r_count}) begin
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = IW'(r_idx + CW'(1));
                        n_state       = ST_SHIFT_WR;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SHIFT_WR: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = IW'(r_idx);
                w_req.wr_data = w_rd_data;
                if (r_cmd == oss_pkg::CMD_INSERT) begin
                    n_idx = r_idx - CW'(1);
                end else begin
                    n_idx = r_idx + CW'(1);
                end
                n_state = ST_SHIFT;
            end
            ST_SEL_WAIT: begin
                n_found = w_rd_data;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                // Load the result once the output register is free.
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_found  = r_found;
                    n_m_rank   = CNTF_W_L'(r_rank);
                    n_m_size   = CNTF_W_L'(r_count);
                    n_m_status = r_status;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_found    <= n_found;
        r_rank     <= n_rank;
        r_status   <= n_status;
        r_m_found  <= n_m_found;
        r_m_rank   <= n_m_rank;
        r_m_size   <= n_m_size;
        r_m_status <= n_m_status;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = oss_pkg::M_TDATA_W'({r_m_size, r_m_rank, r_m_found});
    assign m_axis_tuser  = r_m_status;

    // The fill count never passes the capacity of the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(oss_pkg::CAPACITY))
        else $error("fill count above capacity");

    // A command that has just been taken keeps the block busy next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("ready high straight after a command transfer");

    // The store is written only by the shift engine.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.wr_en |-> (r_state == ST_SHIFT || r_state == ST_SHIFT_WR))
        else $error("store written outside the shift phase");

    // The search window never inverts.
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH || r_state == ST_SRCH_CMP) |-> (r_lo <= r_hi))
        else $error("search bounds crossed");

    // While idle the fill count holds.
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> (r_count == $past(r_count)))
        else $error("fill count changed while idle");

endmodule

@@ tb/order_statistic_set_test.sv @@
// Self-checking testbench for the order statistic set: a short table of directed
// commands, then random phases that fill, drain and mix the set under random stalls.
// Depends on oss_pkg and the order_statistic_set top level.
module order_statistic_set_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_WIDTH = oss_pkg::KEY_WIDTH;
    localparam int CAPACITY  = oss_pkg::CAPACITY;
    localparam int CNTF_W    = oss_pkg::CNTF_W;
    localparam int POS_W     = oss_pkg::POS_W;
    localparam int CMD_W     = oss_pkg::CMD_W;
    localparam int STATUS_W  = oss_pkg::STATUS_W;
    localparam int S_TDATA_W = oss_pkg::S_TDATA_W;
    localparam int M_TDATA_W = oss_pkg::M_TDATA_W;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Longest command is an erase at the bottom of a full set.
    localparam int TAIL_CYCLES  = 400;
    localparam int REPORT_MAX   = 10;

    localparam logic [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
    localparam logic [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

    // One result: the fields of the master tdata plus the status from tuser.
    typedef struct packed {
        logic [KEY_WIDTH-1:0] found;
        logic [CNTF_W-1:0]    rank;
        logic [CNTF_W-1:0]    size;
        oss_pkg::t_status     status;
    } t_set_answer;

    // A directed command; where typed is set, want holds the result read off by hand.
    typedef struct {
        oss_pkg::t_cmd        op;
        logic [KEY_WIDTH-1:0] key;
        logic [POS_W-1:0]     pos;
        bit                   typed;
        t_set_answer          want;
    } t_opening_row;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIX
    } t_phase;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // tdata, lowest bit up: key, position, zero fill.
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // tuser: cmd.
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // tdata, lowest bit up: found_key, rank, set_size, zero fill.
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // tuser: status.
    logic [STATUS_W-1:0]  m_axis_tuser;

    // Keys currently in the set, ascending, as the predictor sees them.
    logic signed [KEY_WIDTH-1:0] held[$];
    // Results still to come back, oldest first.
    t_set_answer answers_due[$];

    int  err_cnt   = 0;
    int  cycle_cnt = 0;
    int  sent_cnt  = 0;
    bit  steady_run = 1'b0;

    // The directed part. Rows marked typed carry their result written out; the
    // rest are left to the predictor. The set is empty at the first row.
    t_opening_row opening_rows [23] = '{
        // Empty set: select has nothing to return, rank and erase see nothing.
        '{oss_pkg::CMD_SELECT, 32'h0, 7'd0, 1'b1, {32'h0, 7'd0, 7'd0, oss_pkg::STS_RANGE}},
        '{oss_pkg::CMD_RANK,   32'h0, 7'd0, 1'b1, {32'h0, 7'd0, 7'd0, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_ERASE,  32'h5, 7'd0, 1'b1, {32'h0, 7'd0, 7'd0, oss_pkg::STS_OK}},
        // Both extremes of the key range, then keys around zero.
        '{oss_pkg::CMD_INSERT, KEY_MIN, 7'd0, 1'b1, {32'h0, 7'd0, 7'd1, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_INSERT, KEY_MAX, 7'd64, 1'b1, {32'h0, 7'd0, 7'd2, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_INSERT, 32'h0, 7'd0, 1'b1, {32'h0, 7'd0, 7'd3, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_INSERT, 32'hFFFF_FFFF, 7'd5, 1'b1, {32'h0, 7'd0, 7'd4, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_INSERT, 32'h1, 7'd0, 1'b1, {32'h0, 7'd0, 7'd5, oss_pkg::STS_OK}},
        // A duplicate leaves the set as it was and is not an error.
        '{oss_pkg::CMD_INSERT, 32'h0, 7'd0, 1'b1, {32'h0, 7'd0, 7'd5, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_SELECT, 32'h1234_5678, 7'd0, 1'b1, {KEY_MIN, 7'd0, 7'd5, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_SELECT, 32'h0, 7'd4, 1'b1, {KEY_MAX, 7'd0, 7'd5, oss_pkg::STS_OK}},
        // Index one past the last key, and an index equal to the capacity.
        '{oss_pkg::CMD_SELECT, 32'h0, 7'd5, 1'b1, {32'h0, 7'd0, 7'd5, oss_pkg::STS_RANGE}},
        '{oss_pkg::CMD_SELECT, 32'hFFFF_FFFF, 7'd64, 1'b1,
          {32'h0, 7'd0, 7'd5, oss_pkg::STS_RANGE}},
        '{oss_pkg::CMD_RANK,   KEY_MIN, 7'd0, 1'b1, {32'h0, 7'd0, 7'd5, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_RANK,   KEY_MAX, 7'd0, 1'b1, {32'h0, 7'd4, 7'd5, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_RANK,   32'h1, 7'd64, 1'b1, {32'h0, 7'd3, 7'd5, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_RANK,   32'h2, 7'd0, 1'b0, '0},
        // Select ignores the key field entirely.
        '{oss_pkg::CMD_SELECT, 32'hDEAD_BEEF, 7'd2, 1'b1, {32'h0, 7'd0, 7'd5, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_ERASE,  KEY_MIN, 7'd0, 1'b1, {32'h0, 7'd0, 7'd4, oss_pkg::STS_OK}},
        // Erasing a key that is no longer there is silently ignored.
        '{oss_pkg::CMD_ERASE,  KEY_MIN, 7'd0, 1'b1, {32'h0, 7'd0, 7'd4, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_ERASE,  KEY_MAX, 7'd0, 1'b1, {32'h0, 7'd0, 7'd3, oss_pkg::STS_OK}},
        '{oss_pkg::CMD_INSERT, 32'h7, 7'd64, 1'b0, '0},
        '{oss_pkg::CMD_RANK,   32'hFFFF_FFFF, 7'd33, 1'b0, '0}
    };

    order_statistic_set DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Number of stored keys strictly below k; also the place where k belongs.
    function automatic int keys_below(logic signed [KEY_WIDTH-1:0] k);
        int n = 0;
        foreach (held[i]) begin
            if (held[i] < k) begin
                n++;
            end
        end
        return n;
    endfunction

    // Applies one command to the predicted set and returns the result it yields.
    function automatic t_set_answer apply_command(oss_pkg::t_cmd op,
                                                  logic signed [KEY_WIDTH-1:0] k,
                                                  logic [POS_W-1:0] p);
        t_set_answer r;
        int          at;
        r  = '0;
        r.status = oss_pkg::STS_OK;
        at = keys_below(k);
        case (op)
            oss_pkg::CMD_INSERT: begin
                // A key already present is left alone, even in a full set.
                if (!(at < held.size() && held[at] == k)) begin
                    if (held.size() >= CAPACITY) begin
                        r.status = oss_pkg::STS_FULL;
                    end else begin
                        held.insert(at, k);
                    end
                end
            end
            oss_pkg::CMD_ERASE: begin
                if (at < held.size() && held[at] == k) begin
                    held.delete(at);
                end
            end
            oss_pkg::CMD_SELECT: begin
                if (p < held.size()) begin
                    r.found = held[p];
                end else begin
                    r.status = oss_pkg::STS_RANGE;
                end
            end
            default: begin
                r.rank = CNTF_W'(at);
            end
        endcase
        r.size = CNTF_W'(held.size());
        return r;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Keys drawn so that hits on stored keys, near misses and extremes are common.
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int roll = $urandom_range(0, 99);
        if (held.size() != 0 && roll < 45) begin
            return held[$urandom_range(0, held.size() - 1)];
        end else if (held.size() != 0 && roll < 55) begin
            return held[$urandom_range(0, held.size() - 1)] + 1;
        end else if (roll < 70) begin
            return KEY_WIDTH'($urandom_range(0, 40)) - KEY_WIDTH'(20);
        end else if (roll < 76) begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Offers one command from a falling edge and holds it until the transfer;
    // returns at the falling edge after it, with any idle gap already taken.
    task automatic send_command(input oss_pkg::t_cmd op, input logic [KEY_WIDTH-1:0] k,
                                input logic [POS_W-1:0] p, input bit typed,
                                input t_set_answer want);
        t_set_answer model;
        int          gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - KEY_WIDTH - POS_W){1'b0}}, p, k};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        // The predictor always runs so that its set tracks the block; a typed
        // row only replaces the result it would have produced.
        model = apply_command(op, k, p);
        if (typed) begin
            model = want;
        end
        answers_due = {answers_due, model};
        sent_cnt++;
        @(negedge i_clk);
        gap = steady_run ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Draws one random command suited to the phase and sends it.
    task automatic send_random(input t_phase phase);
        int                   roll;
        oss_pkg::t_cmd        op;
        logic [KEY_WIDTH-1:0] k;
        logic [POS_W-1:0]     p;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL:  op = roll < 65 ? oss_pkg::CMD_INSERT : roll < 70 ? oss_pkg::CMD_ERASE :
                              roll < 85 ? oss_pkg::CMD_SELECT : oss_pkg::CMD_RANK;
            PHASE_DRAIN: op = roll < 65 ? oss_pkg::CMD_ERASE : roll < 75 ? oss_pkg::CMD_INSERT :
                              roll < 88 ? oss_pkg::CMD_SELECT : oss_pkg::CMD_RANK;
            default:     op = roll < 25 ? oss_pkg::CMD_INSERT : roll < 50 ? oss_pkg::CMD_ERASE :
                              roll < 75 ? oss_pkg::CMD_SELECT : oss_pkg::CMD_RANK;
        endcase
        k = pick_key();
        // Filling wants fresh keys, draining wants keys that are present.
        if (phase == PHASE_FILL && op == oss_pkg::CMD_INSERT
            && $urandom_range(0, 99) < 80) begin
            k = $urandom;
        end else if (phase == PHASE_DRAIN && op == oss_pkg::CMD_ERASE && held.size() != 0
                     && $urandom_range(0, 99) < 70) begin
            k = held[$urandom_range(0, held.size() - 1)];
        end
        if (op == oss_pkg::CMD_SELECT && $urandom_range(0, 99) < 80) begin
            p = POS_W'($urandom_range(0, held.size()));
        end else begin
            p = POS_W'($urandom_range(0, CAPACITY));
        end
        send_command(op, k, p, 1'b0, '0);
    endtask

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        t_phase phase;
        int     span;
        bit     first_phase;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = oss_pkg::CMD_INSERT;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_rows[i]) begin
            send_command(opening_rows[i].op, opening_rows[i].key, opening_rows[i].pos,
                         opening_rows[i].typed, opening_rows[i].want);
        end

        // The first phase is a long fill so that the full set and inserts into
        // it, new keys and duplicates alike, are met early on.
        first_phase = 1'b1;
        while (sent_cnt < RANDOM_ITEMS + $size(opening_rows)) begin
            if (first_phase) begin
                phase = PHASE_FILL;
                span  = 160;
            end else begin
                phase = t_phase'($urandom_range(0, 2));
                span  = $urandom_range(30, 160);
            end
            first_phase = 1'b0;
            steady_run  = ($urandom_range(0, 99) < 20);
            repeat (span) send_random(phase);
        end
        s_axis_tvalid <= 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            note_error($sformatf("%0d results never arrived", answers_due.size()));
        end
        if (err_cnt == 0) begin
            $display("order_statistic_set_test: clean");
        end else begin
            $display("order_statistic_set_test: errors");
        end
        $finish;
    end

    // Result side back-pressure: random stalls between bursts, with an
    // occasional long stretch of constant readiness.
    initial begin
        int stall_left;
        int burst_left;
        stall_left    = 0;
        burst_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    stall_left = idle_len();
                    burst_left = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 300)
                                                             : $urandom_range(0, 20);
                end
            end
        end
    end

    // Each result transfer is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_set_answer got;
        t_set_answer due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.found  = m_axis_tdata[KEY_WIDTH-1:0];
            got.rank   = m_axis_tdata[KEY_WIDTH +: CNTF_W];
            got.size   = m_axis_tdata[KEY_WIDTH + CNTF_W +: CNTF_W];
            got.status = oss_pkg::t_status'(m_axis_tuser);
            if (answers_due.size() == 0) begin
                note_error($sformatf("unexpected result: key %0d rank %0d size %0d status %0d",
                                     $signed(got.found), got.rank, got.size, got.status));
            end else begin
                due = answers_due.pop_front();
                if (got.found !== due.found || got.rank !== due.rank
                    || got.size !== due.size || got.status !== due.status) begin
                    note_error($sformatf({"mismatch: key %0d/%0d rank %0d/%0d ",
                                          "size %0d/%0d status %0d/%0d (expected/actual)"},
                                         $signed(due.found), $signed(got.found),
                                         due.rank, got.rank, due.size, got.size,
                                         due.status, got.status));
                end
            end
        end
    end

    // Guard against a hang: the limit is several times the slowest correct run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("order_statistic_set_test: errors");
            $finish;
        end
    end

endmodule
